/* hw/rtl/nrtp_pkg.sv */
// Shared types, constants and the product schedule of the nearest ray/triangle pick.
// Used by every module of the block; depends on nothing.
package nrtp_pkg;

  localparam int FACE_ID_BITS = 16;
  localparam logic [15:0] FACE_MASK =
    (FACE_ID_BITS >= 16) ? 16'hFFFF : 16'((1 << FACE_ID_BITS) - 1);

  localparam int VEC_W   = 33;   // vertex difference
  localparam int DIR_W   = 18;   // ray direction
  localparam int P_W     = 52;   // dir x e2
  localparam int Q_W     = 67;   // tvec x e1
  localparam int DOT_W   = 88;   // det, u, v numerators
  localparam int ACC_W   = 104;  // accumulator and t numerator
  localparam int LO_W    = 33;   // low chunk of the wide operand
  localparam int CHUNK_W = LO_W + 1;
  localparam int PROD_W  = VEC_W + CHUNK_W;
  localparam int QUO_W   = 31;
  localparam int DEN_W   = DOT_W + QUO_W + 1;
  localparam int N_STEPS = 48;   // 24 products, two passes each
  localparam int STEP_W  = 6;

  typedef enum logic [2:0] {
    REG_ORG_X, REG_ORG_Y, REG_ORG_Z, REG_DIR_X,
    REG_DIR_Y, REG_DIR_Z, REG_DET_EPS, REG_T_MIN
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0]      org_x;
    logic signed [31:0]      org_y;
    logic signed [31:0]      org_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [15:0]             det_eps;
    logic [15:0]             t_min;
  } cfg_t;

  typedef enum logic [1:0] {A_E1, A_E2, A_TV, A_D} a_grp_t;
  typedef enum logic [1:0] {B_D, B_TV, B_P, B_Q} b_grp_t;

  typedef enum logic [3:0] {
    DST_P0, DST_P1, DST_P2, DST_Q0, DST_Q1, DST_Q2,
    DST_DET, DST_UN, DST_VN, DST_TN
  } dst_t;

  typedef struct packed {
    a_grp_t     ag;
    logic [1:0] ak;
    b_grp_t     bg;
    logic [1:0] bk;
    logic       neg;
    logic       last;
    dst_t       dst;
  } prod_op_t;

  typedef struct packed {
    logic valid;
    logic hi;
    logic neg;
    logic last;
    dst_t dst;
  } mac_ctl_t;

  typedef struct packed {
    logic                    valid;
    dst_t                    dst;
    logic signed [ACC_W-1:0] value;
  } mac_store_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_FIX, ST_CHK, ST_DIV, ST_UPD, ST_EMIT
  } state_t;

  // Product j of the schedule: A operand, B operand, subtract, closes a sum.
  function automatic prod_op_t prod_op(input logic [4:0] j);
    prod_op_t o;
    o = '{ag: A_E1, ak: 2'd0, bg: B_D, bk: 2'd0, neg: 1'b0, last: 1'b0, dst: DST_P0};
    case (j)
      5'd0:  o = '{A_E2, 2'd2, B_D,  2'd1, 1'b0, 1'b0, DST_P0};
      5'd1:  o = '{A_E2, 2'd1, B_D,  2'd2, 1'b1, 1'b1, DST_P0};
      5'd2:  o = '{A_E2, 2'd0, B_D,  2'd2, 1'b0, 1'b0, DST_P1};
      5'd3:  o = '{A_E2, 2'd2, B_D,  2'd0, 1'b1, 1'b1, DST_P1};
      5'd4:  o = '{A_E2, 2'd1, B_D,  2'd0, 1'b0, 1'b0, DST_P2};
      5'd5:  o = '{A_E2, 2'd0, B_D,  2'd1, 1'b1, 1'b1, DST_P2};
      5'd6:  o = '{A_E1, 2'd2, B_TV, 2'd1, 1'b0, 1'b0, DST_Q0};
      5'd7:  o = '{A_E1, 2'd1, B_TV, 2'd2, 1'b1, 1'b1, DST_Q0};
      5'd8:  o = '{A_E1, 2'd0, B_TV, 2'd2, 1'b0, 1'b0, DST_Q1};
      5'd9:  o = '{A_E1, 2'd2, B_TV, 2'd0, 1'b1, 1'b1, DST_Q1};
      5'd10: o = '{A_E1, 2'd1, B_TV, 2'd0, 1'b0, 1'b0, DST_Q2};
      5'd11: o = '{A_E1, 2'd0, B_TV, 2'd1, 1'b1, 1'b1, DST_Q2};
      5'd12: o = '{A_E1, 2'd0, B_P,  2'd0, 1'b0, 1'b0, DST_DET};
      5'd13: o = '{A_E1, 2'd1, B_P,  2'd1, 1'b0, 1'b0, DST_DET};
      5'd14: o = '{A_E1, 2'd2, B_P,  2'd2, 1'b0, 1'b1, DST_DET};
      5'd15: o = '{A_TV, 2'd0, B_P,  2'd0, 1'b0, 1'b0, DST_UN};
      5'd16: o = '{A_TV, 2'd1, B_P,  2'd1, 1'b0, 1'b0, DST_UN};
      5'd17: o = '{A_TV, 2'd2, B_P,  2'd2, 1'b0, 1'b1, DST_UN};
      5'd18: o = '{A_D,  2'd0, B_Q,  2'd0, 1'b0, 1'b0, DST_VN};
      5'd19: o = '{A_D,  2'd1, B_Q,  2'd1, 1'b0, 1'b0, DST_VN};
      5'd20: o = '{A_D,  2'd2, B_Q,  2'd2, 1'b0, 1'b1, DST_VN};
      5'd21: o = '{A_E2, 2'd0, B_Q,  2'd0, 1'b0, 1'b0, DST_TN};
      5'd22: o = '{A_E2, 2'd1, B_Q,  2'd1, 1'b0, 1'b0, DST_TN};
      5'd23: o = '{A_E2, 2'd2, B_Q,  2'd2, 1'b0, 1'b1, DST_TN};
      default: ;
    endcase
    return o;
  endfunction

endpackage

/* hw/rtl/nearest_ray_triangle_pick.sv */
// Top level of the nearest ray/triangle pick: sequencer, operand select, pick state.
// Depends on nrtp_pkg, nrtp_cfg, nrtp_mac and nrtp_div.
//
//  channel | handshake                      | word
//  --------+--------------------------------+------------------------------------
//  input   | in_valid / in_ready            | a_*, b_*, c_* vertices, tri_face,
//          |                                | final_tri
//  output  | out_valid / out_ready          | any_hit, hit_face, hit_t
//  config  | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// From one accepted word to the next: the accepting idle state, 24 products through
// the one shared multiplier (each in two chunks), drain, sign fix, bound checks, then
// the serial divider (skipped when the triangle fails the test, cut short when the
// distance saturates), the update and, for a final word, emit.
// in_ready is high only while idle; a final word also waits for the output
// register to drain. Reset is synchronous and leaves the ray at the origin
// pointing along +z, with no hit kept.
module nearest_ray_triangle_pick (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  input  logic [31:0] c_x,
  input  logic [31:0] c_y,
  input  logic [31:0] c_z,
  input  logic [15:0] tri_face,
  input  logic        final_tri,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        any_hit,
  output logic [15:0] hit_face,
  output logic [30:0] hit_t,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nrtp_pkg::*;

  cfg_t cfg;

  state_t state, state_next;

  // triangle working set
  logic signed [VEC_W-1:0] e1 [3];
  logic signed [VEC_W-1:0] e2 [3];
  logic signed [VEC_W-1:0] tv [3];
  logic signed [P_W-1:0]   p  [3];
  logic signed [Q_W-1:0]   q  [3];
  logic signed [DOT_W-1:0] det, un, vn;
  logic signed [ACC_W-1:0] tn;
  logic [15:0]             face;
  logic                    last_tri;
  logic                    ok;

  // pick state
  logic [31:0] nearest_t;
  logic [15:0] nearest_face;
  logic        found;

  logic [STEP_W-1:0] step;
  prod_op_t          op;
  mac_ctl_t          mac_ctl;
  mac_store_t        st;
  logic signed [VEC_W-1:0] opa;
  logic signed [Q_W-1:0]   opb;
  logic signed [DIR_W-1:0] dsel_a, dsel_b;

  logic             div_start, div_done;
  logic [QUO_W-1:0] div_quo;

  logic accept, issue, check_now, upd_now, emit_now;
  logic det_ok, u_ok, v_ok, t_ok, ok_comb;
  logic signed [DOT_W:0] uv;

  nrtp_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  nrtp_mac u_mac (.clk, .rst, .ctl(mac_ctl), .a(opa), .b(opb), .st);

  nrtp_div u_div (
    .clk, .rst, .start(div_start), .num(tn), .den(det), .done(div_done), .quo(div_quo)
  );

  // operand select for the current pass
  assign op = prod_op(step[STEP_W-1:1]);

  function automatic logic signed [DIR_W-1:0] dir_pick(input cfg_t c, input logic [1:0] k);
    logic signed [DIR_W-1:0] r;
    case (k)
      2'd0:    r = c.dir_x;
      2'd1:    r = c.dir_y;
      default: r = c.dir_z;
    endcase
    return r;
  endfunction

  assign dsel_a = dir_pick(cfg, op.ak);
  assign dsel_b = dir_pick(cfg, op.bk);

  always_comb begin
    unique case (op.ag)
      A_E1:    opa = e1[op.ak];
      A_E2:    opa = e2[op.ak];
      A_TV:    opa = tv[op.ak];
      default: opa = {{(VEC_W-DIR_W){dsel_a[DIR_W-1]}}, dsel_a};
    endcase
    unique case (op.bg)
      B_D:     opb = {{(Q_W-DIR_W){dsel_b[DIR_W-1]}}, dsel_b};
      B_TV:    opb = {{(Q_W-VEC_W){tv[op.bk][VEC_W-1]}}, tv[op.bk]};
      B_P:     opb = {{(Q_W-P_W){p[op.bk][P_W-1]}}, p[op.bk]};
      default: opb = q[op.bk];
    endcase
  end

  assign mac_ctl = '{valid: issue, hi: step[0], neg: op.neg,
                     last: op.last && step[0], dst: op.dst};

  // bound checks on the sign-corrected numerators
  assign uv      = un + vn;
  assign det_ok  = (det != '0) && ($unsigned(det) >= DOT_W'({cfg.det_eps, 24'd0}));
  assign u_ok    = !un[DOT_W-1] && (un <= det);
  assign v_ok    = !vn[DOT_W-1] && (uv <= det);
  assign t_ok    = !tn[ACC_W-1];
  assign ok_comb = det_ok && u_ok && v_ok && t_ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MAC;
      ST_MAC:   if (step == STEP_W'(N_STEPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FIX;
      ST_FIX:   state_next = ST_CHK;
      ST_CHK:   state_next = ok_comb ? ST_DIV : ST_UPD;
      ST_DIV:   if (div_done) state_next = ST_UPD;
      ST_UPD:   state_next = last_tri ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    check_now = 1'b0;
    div_start = 1'b0;
    upd_now   = 1'b0;
    emit_now  = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MAC:  issue = 1'b1;
      ST_CHK: begin
        check_now = 1'b1;
        div_start = ok_comb;
      end
      ST_UPD:  upd_now = 1'b1;
      ST_EMIT: emit_now = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst)         step <= '0;
    else if (accept) step <= '0;
    else if (issue)  step <= step + STEP_W'(1);
  end

  // capture edges, store sums, fix signs
  always_ff @(posedge clk) begin
    if (accept) begin
      e1[0] <= {b_x[31], b_x} - {a_x[31], a_x};
      e1[1] <= {b_y[31], b_y} - {a_y[31], a_y};
      e1[2] <= {b_z[31], b_z} - {a_z[31], a_z};
      e2[0] <= {c_x[31], c_x} - {a_x[31], a_x};
      e2[1] <= {c_y[31], c_y} - {a_y[31], a_y};
      e2[2] <= {c_z[31], c_z} - {a_z[31], a_z};
      tv[0] <= {cfg.org_x[31], cfg.org_x} - {a_x[31], a_x};
      tv[1] <= {cfg.org_y[31], cfg.org_y} - {a_y[31], a_y};
      tv[2] <= {cfg.org_z[31], cfg.org_z} - {a_z[31], a_z};
      face     <= tri_face & FACE_MASK;
      last_tri <= final_tri;
    end
    if (st.valid) begin
      unique case (st.dst)
        DST_P0:  p[0] <= st.value[P_W-1:0];
        DST_P1:  p[1] <= st.value[P_W-1:0];
        DST_P2:  p[2] <= st.value[P_W-1:0];
        DST_Q0:  q[0] <= st.value[Q_W-1:0];
        DST_Q1:  q[1] <= st.value[Q_W-1:0];
        DST_Q2:  q[2] <= st.value[Q_W-1:0];
        DST_DET: det  <= st.value[DOT_W-1:0];
        DST_UN:  un   <= st.value[DOT_W-1:0];
        DST_VN:  vn   <= st.value[DOT_W-1:0];
        DST_TN:  tn   <= st.value;
        default: ;
      endcase
    end
    // flip all four numerators when the determinant is negative
    if (state == ST_FIX && det[DOT_W-1]) begin
      det <= -det;
      un  <= -un;
      vn  <= -vn;
      tn  <= -tn;
    end
    if (check_now) ok <= ok_comb;
  end

  // nearest hit and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_t    <= '1;
      nearest_face <= '0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (upd_now && ok && (div_quo > QUO_W'(cfg.t_min)) && ({1'b0, div_quo} < nearest_t)) begin
        nearest_t    <= {1'b0, div_quo};
        nearest_face <= face;
        found        <= 1'b1;
      end
      if (emit_now) begin
        out_valid    <= 1'b1;
        nearest_t    <= '1;
        nearest_face <= '0;
        found        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      any_hit  <= found;
      hit_face <= found ? nearest_face : 16'd0;
      hit_t    <= found ? nearest_t[QUO_W-1:0] : '0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after taking a word");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_hit |-> hit_face == 16'd0 && hit_t == '0)
    else $error("miss reported with nonzero face or distance");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_tn_then_fix: assert property (@(posedge clk) disable iff (rst)
    st.valid && st.dst == DST_TN |=> state == ST_FIX)
    else $error("t numerator stored out of step with the sequencer");

endmodule

/* hw/rtl/nrtp_cfg.sv */
// APB register file holding the ray and the test thresholds.
// Depends on nrtp_pkg.
module nrtp_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output nrtp_pkg::cfg_t       cfg
);
  import nrtp_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{org_x: '0, org_y: '0, org_z: '0, dir_x: '0, dir_y: '0,
               dir_z: 18'sd65536, det_eps: 16'd1, t_min: 16'd66};
    end else if (wr) begin
      unique case (idx)
        REG_ORG_X:   cfg.org_x   <= pwdata;
        REG_ORG_Y:   cfg.org_y   <= pwdata;
        REG_ORG_Z:   cfg.org_z   <= pwdata;
        REG_DIR_X:   cfg.dir_x   <= pwdata[DIR_W-1:0];
        REG_DIR_Y:   cfg.dir_y   <= pwdata[DIR_W-1:0];
        REG_DIR_Z:   cfg.dir_z   <= pwdata[DIR_W-1:0];
        REG_DET_EPS: cfg.det_eps <= pwdata[15:0];
        REG_T_MIN:   cfg.t_min   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORG_X:   prdata = cfg.org_x;
      REG_ORG_Y:   prdata = cfg.org_y;
      REG_ORG_Z:   prdata = cfg.org_z;
      REG_DIR_X:   prdata = {{(32-DIR_W){1'b0}}, cfg.dir_x};
      REG_DIR_Y:   prdata = {{(32-DIR_W){1'b0}}, cfg.dir_y};
      REG_DIR_Z:   prdata = {{(32-DIR_W){1'b0}}, cfg.dir_z};
      REG_DET_EPS: prdata = {16'd0, cfg.det_eps};
      REG_T_MIN:   prdata = {16'd0, cfg.t_min};
      default:     prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/nrtp_mac.sv */
// Shared multiply-accumulate unit: 33x34 signed multiplier, then a 104-bit accumulator.
// Depends on nrtp_pkg.
module nrtp_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  nrtp_pkg::mac_ctl_t            ctl,
  input  logic signed [nrtp_pkg::VEC_W-1:0] a,
  input  logic signed [nrtp_pkg::Q_W-1:0]   b,
  output nrtp_pkg::mac_store_t          st
);
  import nrtp_pkg::*;

  logic signed [CHUNK_W-1:0] bchunk;
  logic signed [PROD_W-1:0]  prod;
  mac_ctl_t                  ctl_q;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   ext;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [ACC_W-1:0]   sum;

  // low chunk is unsigned, high chunk carries the sign
  assign bchunk = ctl.hi ? $signed(b[Q_W-1:LO_W]) : $signed({1'b0, b[LO_W-1:0]});

  always_ff @(posedge clk) begin
    prod <= a * bchunk;
    if (rst) ctl_q <= '0;
    else     ctl_q <= ctl;
  end

  assign ext     = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign shifted = ctl_q.hi ? (ext <<< LO_W) : ext;
  assign sum     = ctl_q.neg ? (acc - shifted) : (acc + shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl_q.valid) begin
      acc <= ctl_q.last ? '0 : sum;
    end
  end

  assign st = '{valid: ctl_q.valid && ctl_q.last, dst: ctl_q.dst, value: sum};

endmodule

/* hw/rtl/nrtp_div.sv */
// Restoring divider, one quotient bit a cycle, saturating at 2^31 - 1.
// Depends on nrtp_pkg.
module nrtp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nrtp_pkg::ACC_W-1:0]    num,
  input  logic [nrtp_pkg::DOT_W-1:0]    den,
  output logic                          done,
  output logic [nrtp_pkg::QUO_W-1:0]    quo
);
  import nrtp_pkg::*;

  logic             busy;
  logic [4:0]       cnt;
  logic [ACC_W-1:0] rem;
  logic [DEN_W-1:0] den_sh;
  logic             ge;

  assign ge = {{(DEN_W-ACC_W){1'b0}}, rem} >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ((cnt == 5'(QUO_W) && ge) || cnt == 5'd0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num;
      den_sh <= {{(DEN_W-DOT_W-QUO_W){1'b0}}, den, {QUO_W{1'b0}}};
      cnt    <= 5'(QUO_W);
      quo    <= '0;
    end else if (busy) begin
      if (cnt == 5'(QUO_W)) begin
        // quotient would not fit: saturate
        if (ge) quo <= '1;
      end else begin
        if (ge) rem <= rem - den_sh[ACC_W-1:0];
        quo <= {quo[QUO_W-2:0], ge};
      end
      den_sh <= den_sh >> 1;
      cnt    <= cnt - 5'd1;
    end
  end

endmodule

/* tb/tb_nearest_ray_triangle_pick.sv */
// Self-checking bench for nearest_ray_triangle_pick: APB ray setup, triangle words in,
// nearest-hit words out, checked against an exact 128-bit pick predictor.
// Depends on nrtp_pkg and the RTL of the block only.
module tb_nearest_ray_triangle_pick;
  import nrtp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 120;

  typedef struct packed {
    logic [8:0][31:0] vtx;   // a_x a_y a_z b_x b_y b_z c_x c_y c_z
    logic [15:0]      face;
    logic             fin;
  } tri_word_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] face;
    logic [30:0] t;
  } pick_word_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [8:0][31:0] vtx_d;
  logic [15:0] face_d;
  logic fin_d;
  logic any_hit;
  logic [15:0] hit_face;
  logic [30:0] hit_t;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  nearest_ray_triangle_pick DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_x(vtx_d[0]), .a_y(vtx_d[1]), .a_z(vtx_d[2]),
    .b_x(vtx_d[3]), .b_y(vtx_d[4]), .b_z(vtx_d[5]),
    .c_x(vtx_d[6]), .c_y(vtx_d[7]), .c_z(vtx_d[8]),
    .tri_face(face_d), .final_tri(fin_d),
    .out_valid(out_valid), .out_ready(out_ready),
    .any_hit(any_hit), .hit_face(hit_face), .hit_t(hit_t),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock: period 20
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Ray registers as the block should hold them, and the running pick state.
  logic signed [31:0] ray_org [3];
  logic signed [17:0] ray_dir [3];
  logic [15:0] det_eps, t_min;
  logic [31:0] near_t;
  logic [15:0] near_face;
  logic        seen_hit;

  tri_word_t  tri_q[$];
  pick_word_t pick_results_q[$];

  logic quiet;            // no idling on either side
  logic long_hold_req, long_hold_done;
  logic in_acc;           // a word was taken at the last rising edge
  int   gap_cnt, hold_cnt, cycles;
  bit   failed;

  // Moller-Trumbore on exact integers; det, u, v and t numerators fit in 128 bits.
  function automatic void ray_tri_test(input logic [8:0][31:0] v,
                                       output logic hit, output logic [31:0] t);
    logic signed [127:0] d[3], e1[3], e2[3], tv[3], p[3], q[3];
    logic signed [127:0] det, un, vn, tn, eps_w;
    for (int k = 0; k < 3; k++) begin
      d[k]  = ray_dir[k];
      e1[k] = $signed(v[3+k]) - $signed(v[k]);
      e2[k] = $signed(v[6+k]) - $signed(v[k]);
      tv[k] = ray_org[k] - $signed(v[k]);
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = tv[1]*e1[2] - tv[2]*e1[1];
    q[1] = tv[2]*e1[0] - tv[0]*e1[2];
    q[2] = tv[0]*e1[1] - tv[1]*e1[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    un  = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
    vn  = d[0]*q[0]  + d[1]*q[1]  + d[2]*q[2];
    tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    eps_w = $signed({112'b0, det_eps}) <<< 24;
    hit = det != 0 && det >= eps_w && un >= 0 && un <= det && vn >= 0 &&
          un + vn <= det && tn >= 0;
    t = 32'hFFFF_FFFF;
    if (hit) begin
      if (tn >= (det <<< 31)) t = 32'h7FFF_FFFF;
      else t = 32'(tn / det);
    end
  endfunction

  // Fold one triangle into the pick; returns 1 and the word when it closes the pick.
  function automatic logic pick_nearest(input tri_word_t w, output pick_word_t r);
    logic hit;
    logic [31:0] t;
    ray_tri_test(w.vtx, hit, t);
    if (hit && t > {16'b0, t_min} && t < near_t) begin
      near_t    = t;
      near_face = w.face & FACE_MASK;
      seen_hit  = 1'b1;
    end
    r = '0;
    if (!w.fin) return 1'b0;
    r.hit  = seen_hit;
    r.face = seen_hit ? near_face : 16'd0;
    r.t    = seen_hit ? near_t[30:0] : 31'd0;
    near_t = 32'hFFFF_FFFF; near_face = '0; seen_hit = 1'b0;
    return 1'b1;
  endfunction

  // Driver: hold the word until taken, then pop the next or idle for a burst.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_acc)) begin
      if (gap_cnt > 0) begin
        gap_cnt  <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (tri_q.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
        gap_cnt  <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (tri_q.size() != 0) begin
        tri_word_t w;
        w = tri_q.pop_front();
        vtx_d    <= w.vtx;
        face_d   <= w.face;
        fin_d    <= w.fin;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_cnt       <= 2000;
        out_ready      <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_cnt  <= $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each taken triangle, check each taken pick word.
  always @(posedge clk) begin
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        tri_word_t  w;
        pick_word_t r;
        w = '{vtx: vtx_d, face: face_d, fin: fin_d};
        if (pick_nearest(w, r)) pick_results_q = {pick_results_q, r};
      end
      if (out_valid && out_ready) begin
        if (pick_results_q.size() == 0) begin
          $display("%0t: unexpected word hit=%0d face=%0d t=%0d", $time,
                   any_hit, hit_face, hit_t);
          failed = 1'b1;
        end else begin
          pick_word_t e;
          e = pick_results_q.pop_front();
          if (any_hit !== e.hit) begin
            $display("%0t: any_hit expected %0d actual %0d", $time, e.hit, any_hit);
            failed = 1'b1;
          end
          if (hit_face !== e.face) begin
            $display("%0t: hit_face expected %0d actual %0d", $time, e.face, hit_face);
            failed = 1'b1;
          end
          if (hit_t !== e.t) begin
            $display("%0t: hit_t expected %0d actual %0d", $time, e.t, hit_t);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ORG_X:   ray_org[0] = value;
      REG_ORG_Y:   ray_org[1] = value;
      REG_ORG_Z:   ray_org[2] = value;
      REG_DIR_X:   ray_dir[0] = value[17:0];
      REG_DIR_Y:   ray_dir[1] = value[17:0];
      REG_DIR_Z:   ray_dir[2] = value[17:0];
      REG_DET_EPS: det_eps    = value[15:0];
      REG_T_MIN:   t_min      = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_ray(input longint ox, oy, oz, dx, dy, dz, eps, tmin);
    apb_write(REG_ORG_X, 32'(ox));
    apb_write(REG_ORG_Y, 32'(oy));
    apb_write(REG_ORG_Z, 32'(oz));
    apb_write(REG_DIR_X, 32'(dx));
    apb_write(REG_DIR_Y, 32'(dy));
    apb_write(REG_DIR_Z, 32'(dz));
    apb_write(REG_DET_EPS, 32'(eps));
    apb_write(REG_T_MIN, 32'(tmin));
  endtask

  task automatic add_tri(input longint ax, ay, az, bx, by, bz, cx, cy, cz,
                         input int face, input bit fin);
    tri_word_t w;
    w.vtx  = {32'(cz), 32'(cy), 32'(cx), 32'(bz), 32'(by), 32'(bx),
              32'(az), 32'(ay), 32'(ax)};
    w.face = 16'(face);
    w.fin  = fin;
    tri_q = {tri_q, w};
  endtask

  // Wait for the input queue and all pick words to drain, then let the block go idle.
  task automatic drain();
    while (tri_q.size() != 0 || in_valid || pick_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic longint rnd_off();
    longint mag;
    mag = longint'(1) << $urandom_range(2, 22);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // Random picks: mostly triangles placed around a point on the ray, some noise.
  task automatic gen_picks(input int n_items);
    int made;
    made = 0;
    while (made < n_items) begin
      int len;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        int kind, face;
        bit fin;
        longint s, cc[3], u1[3], u2[3];
        kind = $urandom_range(0, 9);
        face = $urandom_range(0, 65535);
        fin  = (i == len - 1);
        s = longint'($urandom_range(0, 1 << 22)) - (1 << 18);
        for (int k = 0; k < 3; k++) begin
          cc[k] = longint'(ray_org[k]) + ((longint'(ray_dir[k]) * s) >>> 16);
          u1[k] = rnd_off();
          u2[k] = rnd_off();
        end
        if (kind < 5) begin
          // centroid on the ray
          add_tri(cc[0]+u1[0], cc[1]+u1[1], cc[2]+u1[2], cc[0]+u2[0], cc[1]+u2[1],
                  cc[2]+u2[2], cc[0]-u1[0]-u2[0], cc[1]-u1[1]-u2[1], cc[2]-u1[2]-u2[2],
                  face, fin);
        end else if (kind < 7) begin
          add_tri(cc[0]+u1[0], cc[1]+u1[1], cc[2]+u1[2], cc[0]+u2[0], cc[1]+u2[1],
                  cc[2]+u2[2], cc[0]+rnd_off(), cc[1]+rnd_off(), cc[2]+rnd_off(),
                  face, fin);
        end else if (kind == 7) begin
          // degenerate: all three on one line
          add_tri(cc[0], cc[1], cc[2], cc[0]+u1[0], cc[1]+u1[1], cc[2]+u1[2],
                  cc[0]+2*u1[0], cc[1]+2*u1[1], cc[2]+2*u1[2], face, fin);
        end else begin
          add_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, face, fin || $urandom_range(0, 9) == 0);
        end
        made++;
      end
    end
  endtask

  initial begin
    longint z2;
    rst = 1'b1;
    in_valid = 1'b0; out_ready = 1'b0;
    vtx_d = '0; face_d = '0; fin_d = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    quiet = 1'b0; long_hold_req = 1'b0; long_hold_done = 1'b0;
    gap_cnt = 0; hold_cnt = 0; cycles = 0; failed = 1'b0;
    ray_org = '{0, 0, 0}; ray_dir = '{0, 0, 65536};
    det_eps = 16'd1; t_min = 16'd66;
    near_t = 32'hFFFF_FFFF; near_face = '0; seen_hit = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, ray at reset: origin, +z, eps 1, t minimum 66.
    z2 = 2 * 65536;
    add_tri(-65536, -65536, z2, 65536, -65536, z2, 0, 65536, z2, 7, 1);    // plain hit
    add_tri(0, 0, z2, 65536, 0, z2, 0, 65536, z2, 65535, 1);               // hit on a vertex
    add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 3, 1);                              // zero det
    add_tri(0, 0, z2, 1, 0, z2, 0, 1, z2, 4, 1);                           // small det
    add_tri(-65536, -65536, -z2, 65536, -65536, -z2, 0, 65536, -z2, 5, 1); // behind
    add_tri(-65536, -65536, 50, 65536, -65536, 50, 0, 65536, 50, 6, 1);    // under minimum
    add_tri(-65536, -65536, 66, 65536, -65536, 66, 0, 65536, 66, 8, 1);    // still under minimum
    add_tri(-65536, -65536, 67, 65536, -65536, 67, 0, 65536, 67, 9, 1);    // still under minimum
    add_tri(-65536, -65536, z2, 65536, -65536, z2, 0, 65536, z2, 10, 0);   // tie, both under minimum
    add_tri(-65536, -65536, z2, 65536, -65536, z2, 0, 65536, z2, 11, 0);
    add_tri(-65536, -65536, 65536, 65536, -65536, 65536, 0, 65536, 65536, 0, 1); // nearer
    add_tri(-65536, -65536, 32'h7FFF_FFFF, 65536, -65536, 32'h7FFF_FFFF,
            0, 65536, 32'h7FFF_FFFF, 12, 1);                               // far
    add_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 13, 0);    // extreme bits
    add_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 14, 1);
    add_tri(-65536, -65536, z2, 65536, -65536, z2, 0, 65536, z2, 15, 0);   // miss in
    add_tri(1 << 20, 1 << 20, z2, 2 << 20, 1 << 20, z2, 1 << 20, 2 << 20, z2, 16, 1);
    add_tri(1 << 20, 1 << 20, z2, 2 << 20, 1 << 20, z2, 1 << 20, 2 << 20, z2, 17, 1); // none
    gen_picks(150);
    drain();

    set_ray($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), 0,
            $urandom_range(0, 65536), 40000, 30000, 0, 0);
    gen_picks(230);
    drain();

    // Extreme origin and direction; the receiver holds off for a long stretch.
    long_hold_req = 1'b1;
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, -65536, 65536, 0, 1, 66);
    gen_picks(230);
    drain();

    // Out-of-range direction patterns, largest epsilon and minimum.
    set_ray(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h20000, 32'h1FFFF, 65536, 65535, 65535);
    gen_picks(200);
    drain();

    // Very short direction: distances saturate.
    set_ray(0, 0, 0, 1, 0, 1, 0, 100);
    gen_picks(200);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 2) quiet = 1'b1;
      set_ray($urandom, $urandom, $urandom,
              longint'($urandom_range(0, 131072)) - 65536,
              longint'($urandom_range(0, 131072)) - 65536,
              longint'($urandom_range(0, 131072)) - 65536,
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 4),
              $urandom_range(0, 65535));
      gen_picks(280);
      drain();
    end

    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/nrtp_pkg.sv
hw/rtl/nrtp_cfg.sv
hw/rtl/nrtp_mac.sv
hw/rtl/nrtp_div.sv
hw/rtl/nearest_ray_triangle_pick.sv
tb/tb_nearest_ray_triangle_pick.sv
